@@ design/mer_pkg.sv @@
// Shared widths, codes and types of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

   localparam int COORD_BITS     = 12;
   localparam int RADIUS_BITS    = 11;
   localparam int SQ_BITS        = 2 * RADIUS_BITS;
   localparam int COL_BITS       = 12;
   localparam int ROW_BITS       = 13;
   localparam int OUT_BITS       = 14;
   localparam int GRAD_BITS      = 40;
   localparam int DEC_BITS       = 50;
   localparam int MUL_BITS       = 2 * (COL_BITS + 1);
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CENTER_X,
      REG_CENTER_Y,
      REG_RADIUS_X,
      REG_RADIUS_Y
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_RST_MUL,
      OP_RST_LOAD,
      OP_XSQ,
      OP_BT,
      OP_YSQ,
      OP_AU,
      OP_AB,
      OP_FIN,
      OP_STEP
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RST_MUL,
      ST_RST_LOAD,
      ST_STEP,
      ST_XSQ,
      ST_BT,
      ST_YSQ,
      ST_AU,
      ST_AB,
      ST_FIN
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic finished;
      logic need_switch;
   } dp_status_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]  center_x;
      logic [COORD_BITS-1:0]  center_y;
      logic [RADIUS_BITS-1:0] radius_x;
      logic [RADIUS_BITS-1:0] radius_y;
   } cfg_type;

endpackage

@@ design/mer_ctrl.sv @@
// Sequencing state machine of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

module mer_ctrl
   import mer_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_restart,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff;
      req_stall    = (state_ff != ST_IDLE);
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_restart ? ST_RST_MUL : ST_STEP;
            end
         end
         ST_RST_MUL: begin
            cmd.op   = OP_RST_MUL;
            state_in = ST_RST_LOAD;
         end
         ST_RST_LOAD: begin
            cmd.op   = OP_RST_LOAD;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            priority if (!status.finished && status.need_switch) begin
               state_in = ST_XSQ;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_STEP;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_XSQ: begin
            cmd.op   = OP_XSQ;
            state_in = ST_BT;
         end
         ST_BT: begin
            cmd.op   = OP_BT;
            state_in = ST_YSQ;
         end
         ST_YSQ: begin
            cmd.op   = OP_YSQ;
            state_in = ST_AU;
         end
         ST_AU: begin
            cmd.op   = OP_AU;
            state_in = ST_AB;
         end
         ST_AB: begin
            cmd.op   = OP_AB;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.op   = OP_FIN;
            state_in = ST_STEP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/mer_datapath.sv @@
// Ellipse state, shared multiplier and result register of the rasterizer.
`timescale 1ns / 1ps

module mer_datapath
   import mer_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   output logic                       rsp_point_valid,
   output logic signed [OUT_BITS-1:0] rsp_right_x,
   output logic signed [OUT_BITS-1:0] rsp_left_x,
   output logic signed [OUT_BITS-1:0] rsp_upper_y,
   output logic signed [OUT_BITS-1:0] rsp_lower_y,
   output logic                       rsp_last_step
);

   logic [SQ_BITS-1:0]         sq_x_ff, sq_y_ff;
   logic [COL_BITS-1:0]        x_ff, x_in;
   logic signed [ROW_BITS-1:0] y_ff, y_in;
   logic [GRAD_BITS-1:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic [DEC_BITS-1:0]        d_ff, d_in;
   logic                       r2_ff, r2_in;
   logic [PROD_BITS-1:0]       prod_ff, prod_in;
   logic [DEC_BITS-1:0]        acc_ff, acc_in;

   logic                       pv_ff, pv_in, last_ff, last_in;
   logic [OUT_BITS-1:0]        rx_ff, rx_in, lx_ff, lx_in, uy_ff, uy_in, ly_ff, ly_in;

   logic [MUL_BITS-1:0]        mul_a, mul_b;
   logic [ROW_BITS-1:0]        ym1;
   logic [ROW_BITS-2:0]        ym1_abs;
   logic [GRAD_BITS-1:0]       a2, b2, dx_step, dy_step;
   logic [DEC_BITS-1:0]        a4, b4, dx4, dy4, prod4;
   logic                       finished;

   always_ff @(posedge clock) begin
      sq_x_ff <= SQ_BITS'(cfg.radius_x) * SQ_BITS'(cfg.radius_x);
      sq_y_ff <= SQ_BITS'(cfg.radius_y) * SQ_BITS'(cfg.radius_y);
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      pv_ff   <= pv_in;
      last_ff <= last_in;
      rx_ff   <= rx_in;
      lx_ff   <= lx_in;
      uy_ff   <= uy_in;
      ly_ff   <= ly_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff  <= '0;
         y_ff  <= '1;
         dx_ff <= '0;
         dy_ff <= '0;
         d_ff  <= '0;
         r2_ff <= 1'b0;
      end else begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         d_ff  <= d_in;
         r2_ff <= r2_in;
      end
   end

   assign finished           = y_ff[ROW_BITS-1];
   assign status.finished    = finished;
   assign status.need_switch = !r2_ff && !($signed(dx_ff) < $signed(dy_ff));

   assign ym1     = y_ff - ROW_BITS'(1);
   assign ym1_abs = (y_ff == '0) ? (ROW_BITS-1)'(1) : ym1[ROW_BITS-2:0];

   assign a2      = GRAD_BITS'(sq_x_ff) << 1;
   assign b2      = GRAD_BITS'(sq_y_ff) << 1;
   assign a4      = DEC_BITS'(sq_x_ff) << 2;
   assign b4      = DEC_BITS'(sq_y_ff) << 2;
   assign dx_step = dx_ff + b2;
   assign dy_step = dy_ff - a2;
   assign dx4     = DEC_BITS'($signed(dx_step)) << 2;
   assign dy4     = DEC_BITS'($signed(dy_step)) << 2;
   assign prod4   = DEC_BITS'(prod_ff) << 2;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_RST_MUL: begin
            mul_a = MUL_BITS'(sq_x_ff);
            mul_b = MUL_BITS'(cfg.radius_y);
         end
         OP_XSQ: begin
            mul_a = MUL_BITS'({x_ff, 1'b1});
            mul_b = MUL_BITS'({x_ff, 1'b1});
         end
         OP_BT: begin
            mul_a = MUL_BITS'(sq_y_ff);
            mul_b = prod_ff[MUL_BITS-1:0];
         end
         OP_YSQ: begin
            mul_a = MUL_BITS'(ym1_abs);
            mul_b = MUL_BITS'(ym1_abs);
         end
         OP_AU: begin
            mul_a = MUL_BITS'(sq_x_ff);
            mul_b = prod_ff[MUL_BITS-1:0];
         end
         OP_AB: begin
            mul_a = MUL_BITS'(sq_x_ff);
            mul_b = MUL_BITS'(sq_y_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      d_in    = d_ff;
      r2_in   = r2_ff;
      acc_in  = acc_ff;
      pv_in   = pv_ff;
      last_in = last_ff;
      rx_in   = rx_ff;
      lx_in   = lx_ff;
      uy_in   = uy_ff;
      ly_in   = ly_ff;
      unique case (cmd.op)
         OP_RST_LOAD: begin
            x_in  = '0;
            y_in  = ROW_BITS'(cfg.radius_y);
            dx_in = '0;
            dy_in = GRAD_BITS'(prod_ff) << 1;
            d_in  = b4 - prod4 + DEC_BITS'(sq_x_ff);
            r2_in = 1'b0;
         end
         OP_YSQ: begin
            acc_in = DEC_BITS'(prod_ff);
         end
         OP_AB: begin
            acc_in = acc_ff + prod4;
         end
         OP_FIN: begin
            d_in  = acc_ff - prod4;
            r2_in = 1'b1;
         end
         OP_STEP: begin
            if (finished) begin
               pv_in   = 1'b0;
               last_in = 1'b0;
               rx_in   = '0;
               lx_in   = '0;
               uy_in   = '0;
               ly_in   = '0;
            end else begin
               pv_in   = 1'b1;
               last_in = r2_ff && (y_ff == '0);
               rx_in   = OUT_BITS'(cfg.center_x) + OUT_BITS'(x_ff);
               lx_in   = OUT_BITS'(cfg.center_x) - OUT_BITS'(x_ff);
               uy_in   = OUT_BITS'(cfg.center_y) + OUT_BITS'(y_ff);
               ly_in   = OUT_BITS'(cfg.center_y) - OUT_BITS'(y_ff);
               if (!r2_ff) begin
                  x_in  = x_ff + COL_BITS'(1);
                  dx_in = dx_step;
                  if (d_ff[DEC_BITS-1]) begin
                     d_in = d_ff + dx4 + b4;
                  end else begin
                     y_in  = y_ff - ROW_BITS'(1);
                     dy_in = dy_step;
                     d_in  = d_ff + dx4 - dy4 + b4;
                  end
               end else begin
                  y_in  = y_ff - ROW_BITS'(1);
                  dy_in = dy_step;
                  if (!d_ff[DEC_BITS-1] && (d_ff != '0)) begin
                     d_in = d_ff + a4 - dy4;
                  end else begin
                     x_in  = x_ff + COL_BITS'(1);
                     dx_in = dx_step;
                     d_in  = d_ff + dx4 - dy4 + a4;
                  end
               end
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   assign rsp_point_valid = pv_ff;
   assign rsp_last_step   = last_ff;
   assign rsp_right_x     = rx_ff;
   assign rsp_left_x      = lx_ff;
   assign rsp_upper_y     = uy_ff;
   assign rsp_lower_y     = ly_ff;

endmodule

@@ design/midpoint_ellipse_rasterizer.sv @@
// Top level of the midpoint ellipse rasterizer: registers, controller, datapath.
//
// Write center_x, center_y, radius_x and radius_y on the csr_ port (index 0 to 3)
// while the block is idle. Each req_ item is one step; req_restart high reloads
// the ellipse from the registers and takes its first step in the same item.
// Each item returns exactly one rsp_ item: four mirrored points with
// rsp_point_valid high, or all zeros once the ellipse is finished.
// rsp_last_step marks the final point set.
// A plain step passes ST_STEP, which registers the result; req_stall stays high
// until the controller is back in ST_IDLE. A restart first runs ST_RST_MUL and
// ST_RST_LOAD for the a^2*ry product; the one switch from region one to region
// two runs ST_XSQ to ST_FIN, with five passes through the shared multiplier.
// A result waits in the output register while rsp_stall is high, and one more
// item is taken meanwhile; that item then holds until the register frees.
// Reset clears the registers to zero and leaves the ellipse finished.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer
   import mer_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_point_valid,
   output logic signed [OUT_BITS-1:0]       rsp_right_x,
   output logic signed [OUT_BITS-1:0]       rsp_left_x,
   output logic signed [OUT_BITS-1:0]       rsp_upper_y,
   output logic signed [OUT_BITS-1:0]       rsp_lower_y,
   output logic                             rsp_last_step,
   input  logic                             csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [COORD_BITS-1:0]            csr_write_data
);

   cfg_type       cfg_ff, cfg_in;
   dp_cmd_type    cmd;
   dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_CENTER_X: cfg_in.center_x = csr_write_data;
            REG_CENTER_Y: cfg_in.center_y = csr_write_data;
            REG_RADIUS_X: cfg_in.radius_x = csr_write_data[RADIUS_BITS-1:0];
            REG_RADIUS_Y: cfg_in.radius_y = csr_write_data[RADIUS_BITS-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   mer_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   mer_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .rsp_point_valid (rsp_point_valid),
      .rsp_right_x     (rsp_right_x),
      .rsp_left_x      (rsp_left_x),
      .rsp_upper_y     (rsp_upper_y),
      .rsp_lower_y     (rsp_lower_y),
      .rsp_last_step   (rsp_last_step)
   );

endmodule

@@ dv/midpoint_ellipse_rasterizer_tb.sv @@
// Self-checking testbench for the midpoint ellipse rasterizer: directed and random steps checked against a model.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_tb;
   import mer_pkg::*;

   localparam int STEP_TARGET = 1100;
   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 400;

   typedef struct packed {
      logic                       point_valid;
      logic signed [OUT_BITS-1:0] right_x;
      logic signed [OUT_BITS-1:0] left_x;
      logic signed [OUT_BITS-1:0] upper_y;
      logic signed [OUT_BITS-1:0] lower_y;
      logic                       last_step;
   } point_set_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_restart = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_point_valid;
   logic signed [OUT_BITS-1:0] rsp_right_x;
   logic signed [OUT_BITS-1:0] rsp_left_x;
   logic signed [OUT_BITS-1:0] rsp_upper_y;
   logic signed [OUT_BITS-1:0] rsp_lower_y;
   logic                       rsp_last_step;
   logic                       csr_write_enable = 1'b0;
   reg_index_type              csr_index = REG_CENTER_X;
   logic [COORD_BITS-1:0]      csr_write_data = '0;

   midpoint_ellipse_rasterizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_point_valid  (rsp_point_valid),
      .rsp_right_x      (rsp_right_x),
      .rsp_left_x       (rsp_left_x),
      .rsp_upper_y      (rsp_upper_y),
      .rsp_lower_y      (rsp_lower_y),
      .rsp_last_step    (rsp_last_step),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // Model copy of the registers and the walk state
   logic [COORD_BITS-1:0]  mdl_cx = '0;
   logic [COORD_BITS-1:0]  mdl_cy = '0;
   logic [RADIUS_BITS-1:0] mdl_rx = '0;
   logic [RADIUS_BITS-1:0] mdl_ry = '0;
   int                     col_off = 0;
   int                     row_off = -1;
   logic [63:0]            grad_x = '0;
   logic [63:0]            grad_y = '0;
   logic [63:0]            dval = '0;
   logic                   region_two = 1'b0;

   bit            pending_steps[$];
   point_set_type point_sets_due[$];
   int            items_sent = 0;
   int            mismatch_count = 0;
   int            quiet_cycles = 0;

   bit req_taken = 1'b0;
   bit send_busy = 1'b0;
   int send_gap = 0;
   int send_calm = 0;
   bit rsp_taken = 1'b0;
   int hold_left = 0;
   int recv_calm = 0;
   bit long_hold_req = 1'b0;

   function automatic point_set_type ellipse_step(input logic restart);
      point_set_type      res;
      logic [63:0]        a_sq;
      logic [63:0]        b_sq;
      logic [63:0]        twox1;
      logic signed [63:0] row_m1;
      res = '0;
      a_sq = 64'(mdl_rx) * 64'(mdl_rx);
      b_sq = 64'(mdl_ry) * 64'(mdl_ry);
      if (restart) begin
         col_off = 0;
         row_off = int'(mdl_ry);
         grad_x = '0;
         grad_y = 2 * a_sq * 64'(mdl_ry);
         dval = 4 * b_sq - 4 * a_sq * 64'(mdl_ry) + a_sq;
         region_two = 1'b0;
      end
      if (row_off < 0) return res;
      if (!region_two && !($signed(grad_x) < $signed(grad_y))) begin
         twox1 = 2 * 64'(col_off) + 1;
         row_m1 = row_off - 1;
         region_two = 1'b1;
         dval = b_sq * twox1 * twox1 + 4 * a_sq * (row_m1 * row_m1) - 4 * a_sq * b_sq;
      end
      res.point_valid = 1'b1;
      res.right_x = OUT_BITS'(int'(mdl_cx) + col_off);
      res.left_x  = OUT_BITS'(int'(mdl_cx) - col_off);
      res.upper_y = OUT_BITS'(int'(mdl_cy) + row_off);
      res.lower_y = OUT_BITS'(int'(mdl_cy) - row_off);
      if (!region_two) begin
         col_off++;
         grad_x += 2 * b_sq;
         if ($signed(dval) < 0) begin
            dval += 4 * grad_x + 4 * b_sq;
         end else begin
            row_off--;
            grad_y -= 2 * a_sq;
            dval += 4 * grad_x - 4 * grad_y + 4 * b_sq;
         end
      end else begin
         row_off--;
         grad_y -= 2 * a_sq;
         if ($signed(dval) > 0) begin
            dval += 4 * a_sq - 4 * grad_y;
         end else begin
            col_off++;
            grad_x += 2 * b_sq;
            dval += 4 * grad_x - 4 * grad_y + 4 * a_sq;
         end
         if (row_off < 0) res.last_step = 1'b1;
      end
      return res;
   endfunction

   function automatic void compare_field(string name, logic [OUT_BITS-1:0] want,
                                         logic [OUT_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, name, $signed(want), $signed(got));
         mismatch_count++;
      end
   endfunction

   // Driver: accept at the rising edge, offer the next item at the falling edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         req_taken = 1'b1;
         point_sets_due.push_back(ellipse_step(req_restart));
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            send_busy = 1'b0;
            if (send_calm > 0) begin
               send_calm--;
               send_gap = 0;
            end else begin
               send_gap = $urandom_range(0, 14);
               if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(10, 40);
            end
         end
         if (!send_busy) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_steps.size() != 0) begin
               req_restart <= pending_steps.pop_front();
               send_busy = 1'b1;
            end
         end
         req_valid <= send_busy;
      end
   end

   // Monitor: check at the rising edge, drive the stall at the falling edge
   always @(posedge clock) begin : rsp_check
      point_set_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_taken = 1'b1;
         if (point_sets_due.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %0d %0d %0d %0d %0d %0d",
                     $time, rsp_point_valid, rsp_right_x, rsp_left_x, rsp_upper_y,
                     rsp_lower_y, rsp_last_step);
            mismatch_count++;
         end else begin
            want = point_sets_due.pop_front();
            compare_field("point_valid", OUT_BITS'(want.point_valid), OUT_BITS'(rsp_point_valid));
            compare_field("right_x", want.right_x, rsp_right_x);
            compare_field("left_x", want.left_x, rsp_left_x);
            compare_field("upper_y", want.upper_y, rsp_upper_y);
            compare_field("lower_y", want.lower_y, rsp_lower_y);
            compare_field("last_step", OUT_BITS'(want.last_step), OUT_BITS'(rsp_last_step));
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         if (recv_calm > 0) begin
            recv_calm--;
            hold_left = 0;
         end else begin
            hold_left = $urandom_range(0, 14);
            if ($urandom_range(0, 15) == 0) recv_calm = $urandom_range(10, 40);
         end
      end
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD;
      end
      rsp_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic push_step(input bit restart);
      pending_steps.push_back(restart);
      items_sent++;
   endtask

   task automatic settle();
      while (pending_steps.size() != 0 || send_busy || point_sets_due.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [COORD_BITS-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         REG_CENTER_X: mdl_cx = data;
         REG_CENTER_Y: mdl_cy = data;
         REG_RADIUS_X: mdl_rx = data[RADIUS_BITS-1:0];
         REG_RADIUS_Y: mdl_ry = data[RADIUS_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_shape();
      int pick;
      int rad_x;
      int rad_y;
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
         rad_x = $urandom_range(0, 12);
         rad_y = $urandom_range(0, 12);
      end else if (pick < 19) begin
         rad_x = $urandom_range(0, 2047);
         rad_y = $urandom_range(0, 2047);
      end else begin
         rad_x = $urandom_range(0, 1) ? 2047 : 0;
         rad_y = $urandom_range(0, 1) ? 2047 : 0;
      end
      if ($urandom_range(0, 3) != 0)
         write_reg(REG_CENTER_X, $urandom_range(0, 7) == 0 ? 12'hFFF : 12'($urandom));
      if ($urandom_range(0, 3) != 0)
         write_reg(REG_CENTER_Y, $urandom_range(0, 7) == 0 ? 12'h000 : 12'($urandom));
      write_reg(REG_RADIUS_X, {1'($urandom), 11'(rad_x)});
      write_reg(REG_RADIUS_Y, {1'($urandom), 11'(rad_y)});
   endtask

   initial begin : stimulus
      int phase;
      int n;
      int split_at;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // steps before any restart
      push_step(1'b0);
      push_step(1'b0);
      settle();

      // zero radii at the origin
      write_reg(REG_CENTER_X, 12'h000);
      write_reg(REG_CENTER_Y, 12'h000);
      write_reg(REG_RADIUS_X, 12'h000);
      write_reg(REG_RADIUS_Y, 12'h000);
      push_step(1'b1);
      push_step(1'b0);
      push_step(1'b0);
      settle();

      // largest center and radii, radius writes masked
      write_reg(REG_CENTER_X, 12'hFFF);
      write_reg(REG_CENTER_Y, 12'hFFF);
      write_reg(REG_RADIUS_X, 12'hFFF);
      write_reg(REG_RADIUS_Y, 12'hFFF);
      push_step(1'b1);
      repeat (4) push_step(1'b0);
      settle();

      // small ellipse around the origin, center moved mid-ellipse
      write_reg(REG_CENTER_X, 12'h000);
      write_reg(REG_CENTER_Y, 12'h000);
      write_reg(REG_RADIUS_X, 12'd3);
      write_reg(REG_RADIUS_Y, 12'd5);
      push_step(1'b1);
      repeat (4) push_step(1'b0);
      settle();
      write_reg(REG_CENTER_X, 12'd100);
      repeat (6) push_step(1'b0);
      settle();

      phase = 0;
      while (items_sent < STEP_TARGET) begin
         phase++;
         if (phase == 1 || $urandom_range(0, 3) != 0) random_shape();
         if (int'(mdl_rx) + int'(mdl_ry) <= 40)
            n = int'(mdl_rx) + int'(mdl_ry) + 1 + $urandom_range(0, 3);
         else
            n = $urandom_range(5, 60);
         if (phase == 3) begin
            n = 40;
            @(posedge clock);
            long_hold_req = 1'b1;
         end
         split_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : 0;
         push_step($urandom_range(0, 11) != 0);
         for (int k = 1; k <= n; k++) begin
            if (k == split_at) begin
               settle();
               write_reg(reg_index_type'($urandom_range(0, 3)), 12'($urandom_range(0, 15)));
            end
            push_step($urandom_range(0, 19) == 0);
         end
         settle();
      end

      settle();
      repeat (20) @(posedge clock);
      if (point_sets_due.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, point_sets_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/mer_pkg.sv
design/mer_ctrl.sv
design/mer_datapath.sv
design/midpoint_ellipse_rasterizer.sv
dv/midpoint_ellipse_rasterizer_tb.sv
